@@ rtl/jse_pkg.sv @@
// shared types, character codes and helpers for the json string escaper
package jse_pkg;

  typedef enum logic [2:0] {
    JOB_NONE,
    JOB_CHAR,
    JOB_ESC,
    JOB_U16,
    JOB_PAIR,
    JOB_ERR
  } job_kind_e;

  // one classified input byte: what the back end has to spell out
  typedef struct packed {
    job_kind_e   kind;
    logic [15:0] w0;
    logic [15:0] w1;
    logic        last;
  } job_t;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLowerB    = 8'h62;
  localparam logic [7:0] ChLowerF    = 8'h66;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerU    = 8'h75;

  localparam logic [7:0] CtlBackspace = 8'h08;
  localparam logic [7:0] CtlTab       = 8'h09;
  localparam logic [7:0] CtlNewline   = 8'h0A;
  localparam logic [7:0] CtlFormFeed  = 8'h0C;
  localparam logic [7:0] CtlReturn    = 8'h0D;

  localparam logic [20:0] BmpMax        = 21'h00FFFF;
  localparam logic [20:0] SupplBase     = 21'h010000;
  localparam logic [5:0]  HiSurrogateHi = 6'b110110;
  localparam logic [5:0]  LoSurrogateHi = 6'b110111;

  // lowercase hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = 8'h30 + {4'h0, n};
    end else begin
      c = 8'h57 + {4'h0, n};
    end
    return c;
  endfunction

endpackage

@@ rtl/jse_front.sv @@
// front end: utf-8 decoder and byte classifier, one item per cycle while the queue has room
module jse_front import jse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       last_of_string_i,
  input  logic       full_i,
  output logic       push_o,
  output job_t       job_o
);

  logic        sol_q;
  logic [20:0] cp_q, cp_d;
  logic [1:0]  rem_q, rem_d;
  logic        disc_q, disc_d;

  logic        accept;
  logic        err;
  logic [7:0]  b;
  logic        last;
  logic [20:0] cpn;
  logic [20:0] cofs;
  job_t        job;

  assign accept = in_valid_i && !full_i;
  assign b      = in_byte_i;
  assign last   = last_of_string_i;
  assign cpn    = {cp_q[14:0], b[5:0]};
  assign cofs   = cpn - SupplBase;

  always_comb begin
    cp_d     = cp_q;
    rem_d    = rem_q;
    disc_d   = disc_q;
    err      = 1'b0;
    job.kind = JOB_NONE;
    job.w0   = 16'h0000;
    job.w1   = 16'h0000;
    job.last = last;
    if (accept) begin
      if (disc_q) begin
        if (last) begin
          disc_d = 1'b0;
        end
      end else begin
        if (rem_q == 2'd0) begin
          if (b == ChQuote || b == ChBackslash || (b == ChSlash && sol_q)) begin
            job.kind = JOB_ESC;
            job.w0   = {8'h00, b};
          end else if (b == CtlBackspace) begin
            job.kind = JOB_ESC;
            job.w0   = {8'h00, ChLowerB};
          end else if (b == CtlFormFeed) begin
            job.kind = JOB_ESC;
            job.w0   = {8'h00, ChLowerF};
          end else if (b == CtlNewline) begin
            job.kind = JOB_ESC;
            job.w0   = {8'h00, ChLowerN};
          end else if (b == CtlReturn) begin
            job.kind = JOB_ESC;
            job.w0   = {8'h00, ChLowerR};
          end else if (b == CtlTab) begin
            job.kind = JOB_ESC;
            job.w0   = {8'h00, ChLowerT};
          end else if (b >= 8'h20 && b <= 8'h7E) begin
            job.kind = JOB_CHAR;
            job.w0   = {8'h00, b};
          end else if (b < 8'h80) begin
            job.kind = JOB_U16;
            job.w0   = {8'h00, b};
          end else if (b >= 8'hC2 && b <= 8'hDF) begin
            cp_d  = {16'h0000, b[4:0]};
            rem_d = 2'd1;
          end else if (b >= 8'hE0 && b <= 8'hEF) begin
            cp_d  = {17'h00000, b[3:0]};
            rem_d = 2'd2;
          end else if (b >= 8'hF0 && b <= 8'hF4) begin
            cp_d  = {18'h00000, b[2:0]};
            rem_d = 2'd3;
          end else begin
            err = 1'b1;
          end
        end else if (b[7:6] != 2'b10) begin
          err = 1'b1;
        end else begin
          // first continuation: reject overlong, surrogate and out of range forms
          if (rem_q == 2'd3) begin
            if ((cp_q == 21'd0 && b < 8'h90) || (cp_q == 21'd4 && b > 8'h8F)) begin
              err = 1'b1;
            end
          end else if (rem_q == 2'd2 && cp_q < 21'h10) begin
            if ((cp_q == 21'd0 && b < 8'hA0) || (cp_q == 21'hD && b > 8'h9F)) begin
              err = 1'b1;
            end
          end
          if (!err) begin
            rem_d = rem_q - 2'd1;
            if (rem_d == 2'd0) begin
              cp_d = 21'd0;
              if (cpn <= BmpMax) begin
                job.kind = JOB_U16;
                job.w0   = cpn[15:0];
              end else begin
                job.kind = JOB_PAIR;
                job.w0   = {HiSurrogateHi, cofs[19:10]};
                job.w1   = {LoSurrogateHi, cofs[9:0]};
              end
            end else begin
              cp_d = cpn;
            end
          end
        end
        if (!err && last && rem_d != 2'd0) begin
          err = 1'b1;
        end
        if (err) begin
          cp_d     = 21'd0;
          rem_d    = 2'd0;
          disc_d   = !last;
          job.kind = JOB_ERR;
          job.w0   = 16'h0000;
          job.w1   = 16'h0000;
        end
      end
    end
  end

  assign push_o = accept && (job.kind != JOB_NONE);
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sol_q  <= 1'b0;
      cp_q   <= 21'd0;
      rem_q  <= 2'd0;
      disc_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sol_q <= cfg_data_i;
      end
      cp_q   <= cp_d;
      rem_q  <= rem_d;
      disc_q <= disc_d;
    end
  end

endmodule

@@ rtl/jse_queue.sv @@
// small job queue between front and back ends
module jse_queue import jse_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic full_o,
  output logic not_empty_o,
  output job_t head_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            entry_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o      = (cnt_q == FullCnt);
  assign not_empty_o = (cnt_q != '0);
  assign head_o      = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/jse_back.sv @@
// back end: spells out one output character per cycle, unless the output stalls, into the output register
module jse_back import jse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       not_empty_i,
  input  job_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       run_last_o,
  output logic       string_end_o,
  output logic       bad_utf8_o
);

  localparam logic [2:0] PosLast = 3'd5;

  logic [2:0]  pos_q;
  logic        word_q;
  logic        valid_q;
  logic [7:0]  char_q;
  logic        run_last_q, end_q, bad_q;

  logic        adv;
  logic        fin;
  logic        bad;
  logic [7:0]  ch;
  logic [15:0] word;

  assign word = word_q ? head_i.w1 : head_i.w0;

  always_comb begin
    ch  = 8'h00;
    fin = 1'b1;
    bad = 1'b0;
    unique case (head_i.kind) inside
      JOB_CHAR: ch = head_i.w0[7:0];
      JOB_ESC: begin
        ch  = (pos_q == 3'd0) ? ChBackslash : head_i.w0[7:0];
        fin = (pos_q != 3'd0);
      end
      JOB_U16, JOB_PAIR: begin
        unique case (pos_q)
          3'd0:    ch = ChBackslash;
          3'd1:    ch = ChLowerU;
          3'd2:    ch = hex_char(word[15:12]);
          3'd3:    ch = hex_char(word[11:8]);
          3'd4:    ch = hex_char(word[7:4]);
          default: ch = hex_char(word[3:0]);
        endcase
        fin = (pos_q == PosLast) && (head_i.kind == JOB_U16 || word_q);
      end
      JOB_ERR: bad = 1'b1;
      default: ch = 8'h00;
    endcase
  end

  assign adv   = not_empty_i && (!valid_q || !out_stall_i);
  assign pop_o = adv && fin;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      char_q     <= ch;
      run_last_q <= fin;
      end_q      <= fin && head_i.last;
      bad_q      <= bad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 3'd0;
      word_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      if (adv) begin
        valid_q <= 1'b1;
        if (fin) begin
          pos_q  <= 3'd0;
          word_q <= 1'b0;
        end else if (pos_q == PosLast) begin
          // high surrogate done, move on to the low one
          pos_q  <= 3'd0;
          word_q <= 1'b1;
        end else begin
          pos_q <= pos_q + 3'd1;
        end
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = valid_q;
  assign out_char_o   = char_q;
  assign run_last_o   = run_last_q;
  assign string_end_o = end_q;
  assign bad_utf8_o   = bad_q;

endmodule

@@ rtl/json_string_escaper.sv @@
// top level of the json string escaper
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------------
//  in      | input     | in_valid_i/in_stall_o | in_byte_i, last_of_string_i
//  out     | output    | out_valid_o/out_stall_i | out_char_o, run_last_o, string_end_o,
//          |           |                       | bad_utf8_o
//  cfg     | input     | cfg_we_i              | cfg_data_i (escape_solidus)
//
// one output character leaves per cycle while the output is not stalled; an input byte
// is taken every cycle while the job queue (QueueDepth entries) has room. a job spells
// out 1, 2, 6 or 12 characters (plain, short escape, \uxxxx, surrogate pair), so the
// character sequencer sets the sustained byte rate. reset is asynchronous and
// needs no clearing pass. an output stall holds the result register and backs
// up through the queue to in_stall_o.
module json_string_escaper import jse_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       last_of_string_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       run_last_o,
  output logic       string_end_o,
  output logic       bad_utf8_o
);

  logic q_full, q_not_empty, q_push, q_pop;
  job_t front_job, head_job;

  jse_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_data_i,
    .in_valid_i,
    .in_byte_i,
    .last_of_string_i,
    .full_i (q_full),
    .push_o (q_push),
    .job_o  (front_job)
  );

  jse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (q_push),
    .job_i       (front_job),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .not_empty_o (q_not_empty),
    .head_o      (head_job)
  );

  jse_back u_back (
    .clk_i,
    .rst_ni,
    .not_empty_i (q_not_empty),
    .head_i      (head_job),
    .pop_o       (q_pop),
    .out_valid_o,
    .out_stall_i,
    .out_char_o,
    .run_last_o,
    .string_end_o,
    .bad_utf8_o
  );

  assign in_stall_o = q_full;

  // an error item is a single zero character closing its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_utf8_o |-> out_char_o == 8'h00 && run_last_o)
    else $error("error item with nonzero char or without run_last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_end_o |-> run_last_o)
    else $error("string_end on an item that does not close its byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_not_empty)
    else $error("job queue popped while empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("job queue pushed while full");

endmodule
